FILE: design/edf_pkg.sv
// Shared types and event codes for the deadline scheduler.
`default_nettype none
package edf_pkg;
    typedef enum logic [2:0] {
        K_TICK      = 3'd0,
        K_CREATE    = 3'd1,
        K_WAIT      = 3'd2,
        K_TERMINATE = 3'd3,
        K_SET_DL    = 3'd4
    } t_kind;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    localparam int ID_W = 4;

    // Shift operation driven into every cell of a sorted row.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_row_op;
endpackage
`default_nettype wire

FILE: design/edf_cell.sv
// One slot of a sorted row: holds an entry, compares its key and shifts with its neighbors.
`default_nettype none
module edf_cell #(
    parameter int TW = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rst_valid,
    input  wire logic [TW-1:0]         i_rst_key,
    input  wire edf_pkg::t_row_op      i_op,
    input  wire logic [TW-1:0]         i_new_key,
    input  wire logic [TW-1:0]         i_new_aux,
    input  wire logic [edf_pkg::ID_W-1:0] i_new_id,
    // Neighbor below (index - 1) for insertion shift.
    input  wire logic                  i_prev_valid,
    input  wire logic                  i_prev_after,
    input  wire logic [TW-1:0]         i_prev_key,
    input  wire logic [TW-1:0]         i_prev_aux,
    input  wire logic [edf_pkg::ID_W-1:0] i_prev_id,
    // Neighbor above (index + 1) for pop shift.
    input  wire logic                  i_next_valid,
    input  wire logic [TW-1:0]         i_next_key,
    input  wire logic [TW-1:0]         i_next_aux,
    input  wire logic [edf_pkg::ID_W-1:0] i_next_id,
    output logic                       o_valid,
    output logic                       o_after,
    output logic [TW-1:0]              o_key,
    output logic [TW-1:0]              o_aux,
    output logic [edf_pkg::ID_W-1:0]   o_id
);
    import edf_pkg::*;

    logic              r_valid;
    logic [TW-1:0]     r_key;
    logic [TW-1:0]     r_aux;
    logic [ID_W-1:0]   r_id;

    // An entry goes after this slot when this slot is valid and its key is not larger.
    assign o_after = r_valid && (r_key <= i_new_key);
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_aux   = r_aux;
    assign o_id    = r_id;

    // Shift register behavior for insert and pop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= i_rst_valid;
            r_key   <= i_rst_key;
            r_aux   <= '0;
            r_id    <= '0;
        end else begin
            case (i_op)
                OP_INSERT: begin
                    if (!o_after) begin
                        if (i_prev_after || !i_prev_valid) begin
                            if (i_prev_valid || !r_valid) begin
                                // New entry lands here only at the first slot past the key.
                            end
                        end
                        if (i_prev_after) begin
                            r_valid <= 1'b1;
                            r_key   <= i_new_key;
                            r_aux   <= i_new_aux;
                            r_id    <= i_new_id;
                        end else if (i_prev_valid) begin
                            r_valid <= 1'b1;
                            r_key   <= i_prev_key;
                            r_aux   <= i_prev_aux;
                            r_id    <= i_prev_id;
                        end
                    end
                end
                OP_POP: begin
                    r_valid <= i_next_valid;
                    r_key   <= i_next_key;
                    r_aux   <= i_next_aux;
                    r_id    <= i_next_id;
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/edf_row.sv
// A sorted row built from a chain of cells, with head outputs and a fill count.
`default_nettype none
module edf_row #(
    parameter int TW    = 32,
    parameter int DEPTH = 16,
    parameter bit IDLE_HEAD = 1'b0
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire edf_pkg::t_row_op         i_op,
    input  wire logic [TW-1:0]            i_new_key,
    input  wire logic [TW-1:0]            i_new_aux,
    input  wire logic [edf_pkg::ID_W-1:0] i_new_id,
    output logic                          o_head_valid,
    output logic [TW-1:0]                 o_head_key,
    output logic [TW-1:0]                 o_head_aux,
    output logic [edf_pkg::ID_W-1:0]      o_head_id,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);
    import edf_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    logic [DEPTH:0]  w_valid;
    logic [DEPTH:0]  w_after;
    logic [TW-1:0]   w_key [DEPTH+1];
    logic [TW-1:0]   w_aux [DEPTH+1];
    logic [ID_W-1:0] w_id  [DEPTH+1];
    logic [DEPTH-1:0] w_vprev;
    logic [CW-1:0]   r_count;

    // Ends of the chain: an empty virtual slot past the tail; a virtual slot before the head always precedes the key.
    assign w_valid[DEPTH] = 1'b0;
    assign w_after[DEPTH] = 1'b0;
    assign w_key[DEPTH]   = '0;
    assign w_aux[DEPTH]   = '0;
    assign w_id[DEPTH]    = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic p_valid;
        logic p_after;
        logic [TW-1:0] p_key;
        logic [TW-1:0] p_aux;
        logic [ID_W-1:0] p_id;
        if (g == 0) begin : g_first
            assign p_valid = 1'b0;
            assign p_after = 1'b1;
            assign p_key   = '0;
            assign p_aux   = '0;
            assign p_id    = '0;
        end else begin : g_mid
            assign p_valid = w_valid[g-1];
            assign p_after = w_after[g-1];
            assign p_key   = w_key[g-1];
            assign p_aux   = w_aux[g-1];
            assign p_id    = w_id[g-1];
        end
        assign w_vprev[g] = p_valid;
        edf_cell #(.TW(TW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_rst_valid (IDLE_HEAD && (g == 0)),
            .i_rst_key   ((IDLE_HEAD && (g == 0)) ? {TW{1'b1}} : {TW{1'b0}}),
            .i_op        (i_op),
            .i_new_key   (i_new_key),
            .i_new_aux   (i_new_aux),
            .i_new_id    (i_new_id),
            .i_prev_valid(p_valid),
            .i_prev_after(p_after),
            .i_prev_key  (p_key),
            .i_prev_aux  (p_aux),
            .i_prev_id   (p_id),
            .i_next_valid(w_valid[g+1]),
            .i_next_key  (w_key[g+1]),
            .i_next_aux  (w_aux[g+1]),
            .i_next_id   (w_id[g+1]),
            .o_valid     (w_valid[g]),
            .o_after     (w_after[g]),
            .o_key       (w_key[g]),
            .o_aux       (w_aux[g]),
            .o_id        (w_id[g])
        );
    end

    // Fill count follows the shift operations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= IDLE_HEAD ? CW'(1) : '0;
        end else begin
            case (i_op)
                OP_INSERT: r_count <= r_count + CW'(1);
                OP_POP:    r_count <= r_count - CW'(1);
                default:   r_count <= r_count;
            endcase
        end
    end

    assign o_head_valid = w_valid[0];
    assign o_head_key   = w_key[0];
    assign o_head_aux   = w_aux[0];
    assign o_head_id    = w_id[0];
    assign o_count      = r_count;

    // Valid slots stay packed at the low end and match the fill count.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid[DEPTH-1:0]) == int'(r_count))
        else $error("row fill count disagrees with valid slots");
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid[DEPTH-1:0] & ~w_vprev) == DEPTH'(w_valid[0])))
        else $error("row has a gap");
    a_nopop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_POP) |-> (r_count != '0))
        else $error("pop of an empty row");
endmodule
`default_nettype wire

FILE: design/edf_task_scheduler_top.sv
// Top level of the earliest-deadline-first scheduler: event sequencer around two sorted rows.
//
// Channel   Direction  Signals                                          Handshake
// event     in         i_kind i_task_id i_deadline i_delay              start & !busy
// result    out        o_running_task o_running_deadline o_tick_count   o_done strobe
//                      o_deadline_missed o_status
//
// An accepted create, wait or set-deadline passes the check, put and report states; a terminate,
// a refused event or an unknown kind goes from check straight to report; the result strobe comes
// in the cycle busy drops. A tick loops via wake-put, wake-pop and check once per sleeper woken.
// Every row change is one shift of the cell chain; the sequencer drives at most one in each state.
// Reset is synchronous; busy is low right after reset. Results cannot be stalled.
`default_nettype none
module edf_task_scheduler_top #(
    parameter int MAX_TASKS  = 16,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_kind,
    input  wire logic [3:0]  i_task_id,
    input  wire logic [31:0] i_deadline,
    input  wire logic [31:0] i_delay,
    output logic             o_done,
    output logic [3:0]       o_running_task,
    output logic [31:0]      o_running_deadline,
    output logic [31:0]      o_tick_count,
    output logic             o_deadline_missed,
    output logic [1:0]       o_status
);
    import edf_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int CW = $clog2(MAX_TASKS+1);

    typedef enum logic [2:0] {
        S_IDLE, S_TICK, S_WAKE_PUT, S_WAKE_POP, S_PUT, S_REPORT
    } t_state;

    t_state          r_state;
    logic [2:0]      r_kind;
    logic [ID_W-1:0] r_id;
    logic [TW-1:0]   r_key;
    logic [TW-1:0]   r_aux;
    logic [TW-1:0]   r_delay;
    logic [1:0]      r_status;
    logic [TW-1:0]   r_tick;
    logic            r_to_sleep;

    t_row_op         w_rop, w_sop;
    logic [TW-1:0]   w_rnew_key;
    logic [ID_W-1:0] w_rnew_id;
    logic            w_rhv, w_shv;
    logic [TW-1:0]   w_rhk, w_rha, w_shk, w_sha;
    logic [ID_W-1:0] w_rhid, w_shid;
    logic [CW-1:0]   w_rcnt, w_scnt;
    logic [TW-1:0]   w_wake_raw, w_wake;
    logic [CW:0]     w_total;

    assign w_wake_raw = r_tick + r_delay;
    assign w_wake     = (w_wake_raw > w_rhk) ? w_rhk : w_wake_raw;
    assign w_total    = {1'b0, w_rcnt} + {1'b0, w_scnt};

    // Row commands and inserted entries per state.
    always_comb begin
        w_rop      = OP_HOLD;
        w_sop      = OP_HOLD;
        w_rnew_key = r_key;
        w_rnew_id  = r_id;
        case (r_state)
            S_WAKE_PUT: begin
                w_rop      = OP_INSERT;
                w_rnew_key = w_sha;
                w_rnew_id  = w_shid;
            end
            S_WAKE_POP: w_sop = OP_POP;
            S_PUT: begin
                if (r_to_sleep) w_sop = OP_INSERT;
                else            w_rop = OP_INSERT;
            end
            S_TICK: begin
                if (r_kind == K_WAIT || r_kind == K_TERMINATE || r_kind == K_SET_DL) begin
                    if (r_status == ST_OK) w_rop = OP_POP;
                end
            end
            default: begin
            end
        endcase
    end

    edf_row #(.TW(TW), .DEPTH(MAX_TASKS), .IDLE_HEAD(1'b1)) u_ready (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(w_rop),
        .i_new_key(w_rnew_key), .i_new_aux({TW{1'b0}}), .i_new_id(w_rnew_id),
        .o_head_valid(w_rhv), .o_head_key(w_rhk), .o_head_aux(w_rha),
        .o_head_id(w_rhid), .o_count(w_rcnt)
    );

    // Sleep row: key is the wake time, aux carries the deadline.
    edf_row #(.TW(TW), .DEPTH(MAX_TASKS), .IDLE_HEAD(1'b0)) u_sleep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(w_sop),
        .i_new_key(r_key), .i_new_aux(r_aux), .i_new_id(r_id),
        .o_head_valid(w_shv), .o_head_key(w_shk), .o_head_aux(w_sha),
        .o_head_id(w_shid), .o_count(w_scnt)
    );

    assign busy = (r_state != S_IDLE);

    // Event sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind     <= i_kind;
                        r_id       <= i_task_id;
                        r_key      <= TW'(i_deadline);
                        r_delay    <= TW'(i_delay);
                        r_to_sleep <= 1'b0;
                        r_status   <= ST_OK;
                        if ((i_kind == K_WAIT || i_kind == K_TERMINATE ||
                             i_kind == K_SET_DL) && w_rcnt <= CW'(1))
                            r_status <= ST_IDLE;
                        if (i_kind == K_TICK) r_tick <= r_tick + TW'(1);
                        r_state <= S_TICK;
                    end
                end
                S_TICK: begin
                    r_state <= S_REPORT;
                    case (r_kind)
                        K_TICK: begin
                            if (w_shv && w_shk <= r_tick && w_rcnt < CW'(MAX_TASKS))
                                r_state <= S_WAKE_PUT;
                        end
                        K_CREATE: begin
                            if (w_total >= (CW+1)'(MAX_TASKS)) r_status <= ST_FULL;
                            else r_state <= S_PUT;
                        end
                        K_WAIT: begin
                            if (r_status == ST_OK) begin
                                r_id       <= w_rhid;
                                r_aux      <= w_rhk;
                                r_key      <= w_wake;
                                r_to_sleep <= 1'b1;
                                r_state    <= S_PUT;
                            end
                        end
                        K_SET_DL: begin
                            if (r_status == ST_OK) begin
                                r_id    <= w_rhid;
                                r_state <= S_PUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_WAKE_PUT: r_state <= S_WAKE_POP;
                S_WAKE_POP: r_state <= S_TICK;
                S_PUT:      r_state <= S_REPORT;
                S_REPORT: begin
                    o_done             <= 1'b1;
                    o_running_task     <= w_rhid;
                    o_running_deadline <= 32'(w_rhk);
                    o_tick_count       <= 32'(r_tick);
                    o_deadline_missed  <= (r_tick >= w_rhk);
                    o_status           <= r_status;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The idle entry is always in the ready row and tables never overflow.
    a_ready_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rcnt != '0) && w_rhv)
        else $error("ready row lost the idle entry");
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_total <= (CW+1)'(MAX_TASKS + 1))
        else $error("tables over capacity");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results for one event");
    a_ready_aux_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rha == '0)
        else $error("ready row carries a nonzero aux field");
endmodule
`default_nettype wire
